// ----- sv/spa_pkg.sv -----
// spa_pkg: shared types and codes for the slot pool allocator.
// Depends on nothing; imported by spa_front, spa_back, the top level and the bench.
package spa_pkg;

    // Operation codes of an input word
    typedef enum logic [1:0] {
        OP_GROW    = 2'd0,
        OP_ACQUIRE = 2'd1,
        OP_RELEASE = 2'd2,
        OP_SCAN    = 2'd3
    } op_t;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_BAD_SLOT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_SLOTS = 2'd0;
    localparam logic [1:0] CFG_LIFETIME  = 2'd1;

    localparam logic [6:0]  MAX_SLOTS_RST = 7'd64;
    localparam logic [31:0] LIFETIME_RST  = 32'd60000;

    typedef struct packed {
        logic [1:0]  op;
        logic [6:0]  grow_count;
        logic [5:0]  slot;
        logic [31:0] now_tick;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] granted_slot;
        logic [6:0] affected;
        logic [6:0] free_count;
        logic [6:0] created_count;
    } out_word_t;

    // Classified command handed from front to back
    typedef struct packed {
        op_t         op;
        logic [6:0]  grow_count;
        logic [5:0]  slot;
        logic [31:0] now_tick;
    } cmd_t;

    // Live configuration seen by the back end
    typedef struct packed {
        logic [6:0]  max_slots;
        logic [31:0] lifetime;
    } cfg_t;

endpackage

// ----- sv/spa_ram.sv -----
// spa_ram: generic one-write one-read RAM with registered read data.
// No dependencies.
module spa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/spa_front.sv -----
// spa_front: accepts input words, decodes the op and queues commands.
// Depends on spa_pkg.
module spa_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  spa_pkg::in_word_t in_word,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output spa_pkg::cmd_t     cmd
);
    import spa_pkg::*;

    cmd_t       q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       dec;
    logic       push, pop;

    // Classify the incoming word
    always_comb
    begin
        dec.grow_count = in_word.grow_count;
        dec.slot       = in_word.slot;
        dec.now_tick   = in_word.now_tick;
        unique case (in_word.op)
            OP_GROW:    dec.op = OP_GROW;
            OP_ACQUIRE: dec.op = OP_ACQUIRE;
            OP_RELEASE: dec.op = OP_RELEASE;
            default:    dec.op = OP_SCAN;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    // Two-entry command queue
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("front queue count out of range");
    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2)
        else $error("full queue lost an entry");
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wp_reg == rp_reg)
        else $error("queue pointers disagree with count");
endmodule

// ----- sv/spa_back.sv -----
// spa_back: executes commands against the slot pool state.
// Depends on spa_pkg and spa_ram (free ring and lease stamp memories).
module spa_back #(
    parameter int POOL_SLOTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  spa_pkg::cfg_t      cfg,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  spa_pkg::cmd_t      cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output spa_pkg::out_word_t out_word
);
    import spa_pkg::*;

    localparam int SW = $clog2(POOL_SLOTS);
    localparam int CW = $clog2(POOL_SLOTS + 1);
    localparam logic [CW-1:0] POOL_C  = CW'(POOL_SLOTS);
    localparam logic [SW-1:0] LAST_IX = SW'(POOL_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_GROW, S_ACQ, S_SCAN, S_DONE
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CW-1:0]     created_reg, created_next;
    logic [CW-1:0]     qtot_reg, qtot_next;
    logic [SW-1:0]     head_reg, head_next;
    logic [SW-1:0]     tail_reg, tail_next;
    logic [POOL_SLOTS-1:0] busy_reg, busy_next;
    logic [POOL_SLOTS-1:0] queued_reg, queued_next;
    logic [1:0]        status_reg, status_next;
    logic [SW-1:0]     granted_reg, granted_next;
    logic [CW-1:0]     aff_reg, aff_next;
    logic [CW-1:0]     left_reg, left_next;
    logic [CW-1:0]     lim_reg, lim_next;
    logic [CW-1:0]     sidx_reg, sidx_next;
    logic              pv_reg, pv_next;
    logic [SW-1:0]     pidx_reg, pidx_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_reg, out_next;

    logic [CW-1:0]     cap, room, n_grow;
    logic              enq_req;
    logic [SW-1:0]     enq_slot;
    logic              ring_we;
    logic [SW-1:0]     ring_rdata;
    logic              stamp_we;
    logic [31:0]       stamp_rdata;
    logic [SW-1:0]     rel_idx;
    logic [31:0]       age;

    // Memories: free ring read at head, stamps read at the scan index
    spa_ram #(.WIDTH(SW), .DEPTH(POOL_SLOTS)) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (tail_reg),
        .wdata (enq_slot),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    spa_ram #(.WIDTH(32), .DEPTH(POOL_SLOTS)) u_stamp (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (ring_rdata),
        .wdata (cmd_reg.now_tick),
        .raddr (sidx_reg[SW-1:0]),
        .rdata (stamp_rdata)
    );

    // Effective cap, free room and grow size
    always_comb
    begin
        cap = ({25'd0, cfg.max_slots} > 32'(POOL_SLOTS)) ? POOL_C : CW'(cfg.max_slots);
        room = (created_reg < cap) ? cap - created_reg : '0;
        n_grow = ({25'd0, cmd.grow_count} < 32'(room)) ? CW'(cmd.grow_count) : room;
        rel_idx = SW'(32'(cmd.slot));
        age = cmd_reg.now_tick - stamp_rdata;
    end

    assign cmd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        created_next = created_reg;
        qtot_next    = qtot_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        busy_next    = busy_reg;
        queued_next  = queued_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        aff_next     = aff_reg;
        left_next    = left_reg;
        lim_next     = lim_reg;
        sidx_next    = sidx_reg;
        pv_next      = 1'b0;
        pidx_next    = pidx_reg;
        out_next     = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        enq_req      = 1'b0;
        enq_slot     = '0;
        ring_we      = 1'b0;
        stamp_we     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next     = cmd;
                    status_next  = ST_OK;
                    granted_next = '0;
                    aff_next     = '0;
                    unique case (cmd.op)
                        OP_GROW:
                        begin
                            aff_next   = n_grow;
                            left_next  = n_grow;
                            state_next = (n_grow == '0) ? S_DONE : S_GROW;
                        end
                        OP_ACQUIRE:
                        begin
                            if (qtot_reg == '0)
                            begin
                                status_next = ST_NO_FREE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_ACQ;
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (32'(cmd.slot) >= 32'(created_reg))
                            begin
                                status_next = ST_BAD_SLOT;
                            end
                            else
                            begin
                                busy_next[rel_idx] = 1'b0;
                                enq_req  = 1'b1;
                                enq_slot = rel_idx;
                            end
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            lim_next   = (created_reg < cap) ? created_reg : cap;
                            sidx_next  = '0;
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end
            // One new slot per cycle
            S_GROW:
            begin
                busy_next[created_reg[SW-1:0]] = 1'b0;
                enq_req      = 1'b1;
                enq_slot     = created_reg[SW-1:0];
                created_next = created_reg + 1'b1;
                left_next    = left_reg - 1'b1;
                if (left_reg == CW'(1))
                begin
                    state_next = S_DONE;
                end
            end
            // Ring head data is back: pop it
            S_ACQ:
            begin
                head_next = (head_reg == LAST_IX) ? '0 : head_reg + 1'b1;
                qtot_next = qtot_reg - 1'b1;
                queued_next[ring_rdata] = 1'b0;
                busy_next[ring_rdata]   = 1'b1;
                stamp_we     = 1'b1;
                granted_next = ring_rdata;
                state_next   = S_DONE;
            end
            // Read stamp of one slot per cycle, judge it the next cycle
            S_SCAN:
            begin
                if (sidx_reg < lim_reg)
                begin
                    pv_next   = 1'b1;
                    pidx_next = sidx_reg[SW-1:0];
                    sidx_next = sidx_reg + 1'b1;
                end
                if (pv_reg && busy_reg[pidx_reg] && (age > cfg.lifetime))
                begin
                    busy_next[pidx_reg] = 1'b0;
                    enq_req  = 1'b1;
                    enq_slot = pidx_reg;
                    aff_next = aff_reg + 1'b1;
                end
                if (sidx_reg >= lim_reg && !pv_reg)
                begin
                    state_next = S_DONE;
                end
            end
            default:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.status        = status_reg;
                    out_next.granted_slot  = 6'(granted_reg);
                    out_next.affected      = 7'(aff_reg);
                    out_next.free_count    = 7'(qtot_reg);
                    out_next.created_count = 7'(created_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase

        // Shared enqueue onto the free ring
        if (enq_req && !queued_reg[enq_slot] && qtot_reg < POOL_C)
        begin
            ring_we     = 1'b1;
            queued_next[enq_slot] = 1'b1;
            tail_next   = (tail_reg == LAST_IX) ? '0 : tail_reg + 1'b1;
            qtot_next   = qtot_reg + 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        out_reg  <= out_next;
        granted_reg <= granted_next;
        aff_reg  <= aff_next;
        left_reg <= left_next;
        lim_reg  <= lim_next;
        pidx_reg <= pidx_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            created_reg   <= '0;
            qtot_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            busy_reg      <= '0;
            queued_reg    <= '0;
            sidx_reg      <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            created_reg   <= created_next;
            qtot_reg      <= qtot_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            busy_reg      <= busy_next;
            queued_reg    <= queued_next;
            sidx_reg      <= sidx_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_qtot_marks: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(queued_reg) == 32'(qtot_reg))
        else $error("queued marks disagree with queued total");
    a_created_cap: assert property (@(posedge clk) disable iff (!rst_n)
        created_reg <= POOL_C) else $error("created total above pool size");
    a_acq_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACQ |-> qtot_reg != '0)
        else $error("pop from an empty free ring");
    a_busy_not_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg & queued_reg) == '0) else $error("slot both busy and queued");
endmodule

// ----- sv/slot_pool_allocator_with_lease_timeout.sv -----
// Slot pool allocator with lease timeout: top level, config registers.
// Depends on spa_pkg, spa_front, spa_back (which uses spa_ram).
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_word  (op, grow_count, slot, now_tick)
//  out     | output    | out_valid / out_ready | out_word (status, slot, counts)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Back end per word: a release acts on accept, an acquire reads the ring then pops it,
// a grow creates one slot per step, a scan walks the slots; then the result is loaded.
// The one-slot-per-cycle walk of grow and scan sets the worst case.
// Reset is immediate: all slot marks are flip-flops, no clearing pass.
// A two-entry command queue and the output register let input and output stall
// independently; cfg_ready is always high.
module slot_pool_allocator_with_lease_timeout #(
    parameter int POOL_SLOTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  spa_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output spa_pkg::out_word_t out_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import spa_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic cmd_valid, cmd_ready;
    cmd_t cmd;

    assign cfg_ready = 1'b1;

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_SLOTS: cfg_next.max_slots = cfg_data[6:0];
                CFG_LIFETIME:  cfg_next.lifetime  = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_slots <= MAX_SLOTS_RST;
            cfg_reg.lifetime  <= LIFETIME_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    spa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    spa_back #(.POOL_SLOTS(POOL_SLOTS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );
endmodule

// ----- tb/tb_slot_pool_allocator_with_lease_timeout.sv -----
// Self-checking bench for the slot pool allocator with lease timeout.
// Depends on spa_pkg and slot_pool_allocator_with_lease_timeout.
`timescale 1ns / 100ps
module tb_slot_pool_allocator_with_lease_timeout;
    import spa_pkg::*;

    localparam int SLOTS = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_word_t in_word = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_word_t out_word;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // shadow of the pool
    logic [6:0] cap_reg;
    logic [31:0] life_reg;
    int created_n;
    int queued_n;
    int head_ptr;
    int tail_ptr;
    bit busy_q[SLOTS];
    bit queued_q[SLOTS];
    logic [31:0] stamp_q[SLOTS];
    int ring_q[SLOTS];

    out_word_t pending_results[$];
    int fail_count = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;      // no random idling
    bit hold_off = 1'b0;  // long receiver stall

    slot_pool_allocator_with_lease_timeout uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int eff_cap();
        return (cap_reg > SLOTS) ? SLOTS : int'(cap_reg);
    endfunction

    function automatic void queue_slot(int s);
        if (queued_q[s] || queued_n >= SLOTS)
            return;
        ring_q[tail_ptr] = s;
        tail_ptr = (tail_ptr + 1) % SLOTS;
        queued_q[s] = 1'b1;
        queued_n++;
    endfunction

    function automatic void free_one(int s);
        busy_q[s] = 1'b0;
        stamp_q[s] = '0;
        queue_slot(s);
    endfunction

    function automatic void pool_reset();
        cap_reg = MAX_SLOTS_RST;
        life_reg = LIFETIME_RST;
        created_n = 0;
        queued_n = 0;
        head_ptr = 0;
        tail_ptr = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            busy_q[i] = 1'b0;
            queued_q[i] = 1'b0;
            stamp_q[i] = '0;
            ring_q[i] = 0;
        end
    endfunction

    // Compute the expected result of one word and advance the shadow
    function automatic out_word_t pool_step(in_word_t w);
        out_word_t r;
        int n;
        int lim;
        int s;
        r = '0;
        case (op_t'(w.op))
            OP_GROW:
            begin
                n = eff_cap() - created_n;
                if (n < 0) n = 0;
                if (int'(w.grow_count) < n) n = int'(w.grow_count);
                for (int i = 0; i < n; i++)
                begin
                    busy_q[created_n] = 1'b0;
                    stamp_q[created_n] = '0;
                    queue_slot(created_n);
                    created_n++;
                end
                r.affected = 7'(n);
            end
            OP_ACQUIRE:
            begin
                if (queued_n == 0)
                    r.status = ST_NO_FREE;
                else
                begin
                    s = ring_q[head_ptr];
                    head_ptr = (head_ptr + 1) % SLOTS;
                    queued_n--;
                    queued_q[s] = 1'b0;
                    busy_q[s] = 1'b1;
                    stamp_q[s] = w.now_tick;
                    r.granted_slot = 6'(s);
                end
            end
            OP_RELEASE:
            begin
                if (int'(w.slot) >= created_n)
                    r.status = ST_BAD_SLOT;
                else if (busy_q[w.slot])
                    free_one(int'(w.slot));
                else
                    queue_slot(int'(w.slot));
            end
            default:
            begin
                lim = (created_n < eff_cap()) ? created_n : eff_cap();
                n = 0;
                for (int i = 0; i < lim; i++)
                    if (busy_q[i] && (w.now_tick - stamp_q[i]) > life_reg)
                    begin
                        free_one(i);
                        n++;
                    end
                r.affected = 7'(n);
            end
        endcase
        r.free_count = 7'(queued_n);
        r.created_count = 7'(created_n);
        return r;
    endfunction

    // Send one word and queue its expected result; valid stays high after
    // the accept so that the next word can follow with no gap
    task automatic send_word(op_t op, int cnt, int s, logic [31:0] tick);
        in_word_t w;
        w.op = op;
        w.grow_count = 7'(cnt);
        w.slot = 6'(s);
        w.now_tick = tick;
        while (!calm && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(pool_step(w));
    endtask

    task automatic random_word(logic [31:0] base);
        int k;
        k = $urandom_range(99);
        if (k < 10)
            send_word(OP_GROW, $urandom_range(127), $urandom_range(63), $urandom);
        else if (k < 45)
            send_word(OP_ACQUIRE, $urandom_range(127), $urandom_range(63),
                      base + $urandom_range(3000));
        else if (k < 80)
            send_word(OP_RELEASE, $urandom_range(127), $urandom_range(63), $urandom);
        else if (k < 95)
            send_word(OP_SCAN, $urandom_range(127), $urandom_range(63),
                      base + $urandom_range(6000));
        else
            send_word(op_t'($urandom_range(3)), $urandom_range(127),
                      $urandom_range(63), $urandom);
    endtask

    // Register write while the block is idle
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_MAX_SLOTS)
            cap_reg = val[6:0];
        else
            life_reg = val;
    endtask

    task automatic test_directed();
        send_word(OP_ACQUIRE, 0, 0, 32'd5);              // empty ring
        send_word(OP_RELEASE, 0, 63, 32'd0);             // uncreated slot
        send_word(OP_GROW, 0, 0, 32'd0);
        send_word(OP_GROW, 3, 0, 32'd0);
        send_word(OP_ACQUIRE, 0, 0, 32'd100);
        send_word(OP_ACQUIRE, 0, 0, 32'hFFFF_FFFF);
        send_word(OP_RELEASE, 0, 2, 32'd0);              // already queued
        send_word(OP_RELEASE, 127, 0, 32'd0);            // busy slot freed
        send_word(OP_SCAN, 0, 0, 32'd60000);
        send_word(OP_SCAN, 0, 0, 32'd59999);             // wrapped age
        send_word(OP_GROW, 127, 0, 32'd0);               // fill to pool size
        send_word(OP_GROW, 64, 0, 32'd0);                // pool full
        send_word(OP_RELEASE, 0, 63, 32'hFFFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_word(OP_ACQUIRE, 0, 0, 32'd10);
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_LIFETIME, 32'd0);
        send_word(OP_SCAN, 0, 0, 32'd11);
        write_reg(CFG_LIFETIME, 32'hFFFF_FFFF);
        send_word(OP_ACQUIRE, 0, 0, 32'd1);
        send_word(OP_SCAN, 0, 0, 32'd0);
        write_reg(CFG_MAX_SLOTS, 32'd1);                 // lowered cap
        send_word(OP_SCAN, 0, 0, 32'hFFFF_FFFF);
        send_word(OP_GROW, 5, 0, 32'd0);
        write_reg(CFG_MAX_SLOTS, 32'd0);
        send_word(OP_GROW, 5, 0, 32'd0);
        write_reg(CFG_MAX_SLOTS, 32'd127);               // above the pool
        send_word(OP_GROW, 5, 0, 32'd0);
    endtask

    task automatic test_random(int n_words, logic [6:0] cap, logic [31:0] life);
        logic [31:0] base;
        write_reg(CFG_MAX_SLOTS, 32'(cap));
        write_reg(CFG_LIFETIME, life);
        base = $urandom;
        for (int i = 0; i < n_words; i++)
        begin
            random_word(base);
            base += $urandom_range(40);
        end
    endtask

    task automatic test_backpressure();
        calm = 1'b1;
        hold_off = 1'b1;
        for (int i = 0; i < 30; i++)
            random_word(32'd0);
        hold_off = 1'b0;
        for (int i = 0; i < 60; i++)
            random_word(32'd500);
        calm = 1'b0;
    endtask

    // Receiver: random stalls, long hold-off, compare
    always @(posedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= 9);
        if (rst_n && out_valid && out_ready)
        begin
            out_word_t e;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (out_word.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, out_word.status);
                    fail_count++;
                end
                if (out_word.granted_slot !== e.granted_slot)
                begin
                    $error("granted_slot exp %0d got %0d", e.granted_slot,
                           out_word.granted_slot);
                    fail_count++;
                end
                if (out_word.affected !== e.affected)
                begin
                    $error("affected exp %0d got %0d", e.affected, out_word.affected);
                    fail_count++;
                end
                if (out_word.free_count !== e.free_count)
                begin
                    $error("free_count exp %0d got %0d", e.free_count,
                           out_word.free_count);
                    fail_count++;
                end
                if (out_word.created_count !== e.created_count)
                begin
                    $error("created_count exp %0d got %0d", e.created_count,
                           out_word.created_count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("slot_pool_allocator_with_lease_timeout verification failed");
            $finish;
        end
    end

    // Hold-off length is counted in cycles on its own
    initial
    begin
        wait (hold_off);
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        pool_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_random(140, 7'd64, 32'd2000);
        test_random(120, 7'd12, 32'd300);
        test_random(120, 7'd1, 32'd0);
        calm = 1'b1;
        test_random(60, 7'd40, 32'd1000);
        calm = 1'b0;
        test_backpressure();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 10) @(posedge clk);
        $display("Covered directed corners, cap and lifetime extremes, random traffic");
        $display("and a long output stall; %0d results checked", results_seen);
        if (fail_count == 0)
            $display("slot_pool_allocator_with_lease_timeout verification clean");
        else
            $display("slot_pool_allocator_with_lease_timeout verification failed");
        $finish;
    end
endmodule
